### src/frs_pkg.sv
// Package for the flash request splitter: transaction payload types,
// status, piece kind and register index codes. No dependencies.
`default_nettype none

package frs_pkg;

   // Operation codes
   localparam logic [1:0] OP_PROGRAM = 2'd0;
   localparam logic [1:0] OP_ERASE   = 2'd1;
   localparam logic [1:0] OP_CHIP    = 2'd2;

   // Status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_EMPTY_PROG  = 3'd1;
   localparam logic [2:0] STATUS_UNALIGN_ADR = 3'd2;
   localparam logic [2:0] STATUS_UNALIGN_LEN = 3'd3;
   localparam logic [2:0] STATUS_TOO_MANY    = 3'd4;
   localparam logic [2:0] STATUS_EMPTY_ERASE = 3'd5;

   // Piece kinds
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_PROGRAM = 3'd1;
   localparam logic [2:0] KIND_SECTOR  = 3'd2;
   localparam logic [2:0] KIND_BLOCK   = 3'd3;
   localparam logic [2:0] KIND_CHIP    = 3'd4;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_PAGE_LOG2    = 3'd0;
   localparam logic [2:0] REG_SECTOR_LOG2  = 3'd1;
   localparam logic [2:0] REG_BLOCK_LOG2   = 3'd2;
   localparam logic [2:0] REG_PROGRAM_OP   = 3'd3;
   localparam logic [2:0] REG_SECTOR_OP    = 3'd4;
   localparam logic [2:0] REG_BLOCK_OP     = 3'd5;
   localparam logic [2:0] REG_CHIP_OP      = 3'd6;

   typedef struct packed {
      logic [1:0]  operation;
      logic [23:0] start_address;
      logic [24:0] byte_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  piece_kind;
      logic [7:0]  opcode;
      logic [23:0] piece_address;
      logic [20:0] piece_length;
      logic [23:0] data_offset;
      logic        last_piece;
   } rsp_type;

   // Single status-only result, always the last of its transaction
   function automatic rsp_type status_result(input logic [2:0] code);
      rsp_type r;
      r               = '0;
      r.status        = code;
      r.piece_kind    = KIND_NONE;
      r.last_piece    = 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/flash_request_splitter_top.sv
// Flash request splitter, top level: APB register file, sequencer and
// shared piece-step unit. Depends on frs_pkg.
`default_nettype none

// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+-------------------------------
// request   | start, busy, req_data (req_type)    | taken when start & !busy
// response  | rsp_valid, rsp_data (rsp_type)      | one-cycle strobe, no back-pressure
// registers | psel penable pwrite paddr pwdata    | written on psel&penable&pwrite
//           | prdata pready                       | pready tied high
//
// Sequence: chip erase and every error found on the request itself give their single
// result in the cycle after the request is taken, and the block is free again at once.
// A split request runs the shared step unit twice over its pieces: a counting pass
// to find out whether it fits, then an emitting pass with one piece per cycle. A
// request that needs too many pieces ends its counting pass with the single
// too-many status result.
// Reset: synchronous, active high; registers return to their documented defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.

module flash_request_splitter_top
   import frs_pkg::*;
#(
   parameter int MAX_PIECES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request transaction
   input  wire logic        start,
   output      logic        busy,
   input  wire req_type     req_data,
   // response transaction
   output      logic        rsp_valid,
   output      rsp_type     rsp_data,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam int CNT_W = $clog2(MAX_PIECES + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_COUNT = 3'b010,
      S_EMIT  = 3'b100
   } state_type;

   // ------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------
   logic [3:0] page_log2_ff;
   logic [4:0] sector_log2_ff;
   logic [4:0] block_log2_ff;
   logic [7:0] program_op_ff;
   logic [7:0] sector_op_ff;
   logic [7:0] block_op_ff;
   logic [7:0] chip_op_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_log2_ff   <= 4'd8;
         sector_log2_ff <= 5'd12;
         block_log2_ff  <= 5'd16;
         program_op_ff  <= 8'h02;
         sector_op_ff   <= 8'h20;
         block_op_ff    <= 8'hD8;
         chip_op_ff     <= 8'hC7;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_PAGE_LOG2:   page_log2_ff   <= pwdata[3:0];
            REG_SECTOR_LOG2: sector_log2_ff <= pwdata[4:0];
            REG_BLOCK_LOG2:  block_log2_ff  <= pwdata[4:0];
            REG_PROGRAM_OP:  program_op_ff  <= pwdata[7:0];
            REG_SECTOR_OP:   sector_op_ff   <= pwdata[7:0];
            REG_BLOCK_OP:    block_op_ff    <= pwdata[7:0];
            REG_CHIP_OP:     chip_op_ff     <= pwdata[7:0];
            default: ;       // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_PAGE_LOG2:   prdata = {28'd0, page_log2_ff};
         REG_SECTOR_LOG2: prdata = {27'd0, sector_log2_ff};
         REG_BLOCK_LOG2:  prdata = {27'd0, block_log2_ff};
         REG_PROGRAM_OP:  prdata = {24'd0, program_op_ff};
         REG_SECTOR_OP:   prdata = {24'd0, sector_op_ff};
         REG_BLOCK_OP:    prdata = {24'd0, block_op_ff};
         REG_CHIP_OP:     prdata = {24'd0, chip_op_ff};
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Geometry: saturate the size registers, block never below sector
   // ------------------------------------------------------------------
   logic [4:0]  page_log2;
   logic [4:0]  sector_log2;
   logic [4:0]  block_log2;
   logic [24:0] page_size, sector_size, block_size;
   logic [24:0] page_mask, sector_mask, block_mask;

   always_comb begin
      priority if (page_log2_ff < 4'd4)  page_log2 = 5'd4;
      else if (page_log2_ff > 4'd12)     page_log2 = 5'd12;
      else                               page_log2 = {1'b0, page_log2_ff};

      priority if (sector_log2_ff < 5'd9) sector_log2 = 5'd9;
      else if (sector_log2_ff > 5'd16)    sector_log2 = 5'd16;
      else                                sector_log2 = sector_log2_ff;

      priority if (block_log2_ff < 5'd12) block_log2 = 5'd12;
      else if (block_log2_ff > 5'd20)     block_log2 = 5'd20;
      else                                block_log2 = block_log2_ff;
      if (block_log2 < sector_log2) block_log2 = sector_log2;
   end

   assign page_size   = 25'd1 << page_log2;
   assign sector_size = 25'd1 << sector_log2;
   assign block_size  = 25'd1 << block_log2;
   assign page_mask   = page_size - 25'd1;
   assign sector_mask = sector_size - 25'd1;
   assign block_mask  = block_size - 25'd1;

   // ------------------------------------------------------------------
   // Sequencer state and latched request
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [23:0]      addr_ff, addr_in;
   logic [24:0]      len_ff, len_in;
   logic [24:0]      off_ff, off_in;      // offset of current piece
   logic [24:0]      rem_ff, rem_in;      // bytes still to cover
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------
   // Shared step unit: one piece from (address, offset, remainder)
   // ------------------------------------------------------------------
   logic [23:0] step_addr;
   logic [24:0] page_room;
   logic [24:0] step_len;
   logic [24:0] step_rem;
   logic [2:0]  step_kind;
   logic [7:0]  step_op;
   logic        use_block;

   assign step_addr = addr_ff + off_ff[23:0];
   assign page_room = page_size - ({1'b0, step_addr} & page_mask);
   assign use_block = (({1'b0, step_addr} & block_mask) == 25'd0) && (rem_ff >= block_size);

   always_comb begin
      if (op_ff == OP_PROGRAM) begin
         step_kind = KIND_PROGRAM;
         step_op   = program_op_ff;
         step_len  = (page_room < rem_ff) ? page_room : rem_ff;
         step_rem  = rem_ff - step_len;
      end else if (use_block) begin
         step_kind = KIND_BLOCK;
         step_op   = block_op_ff;
         step_len  = block_size;
         step_rem  = rem_ff - block_size;
      end else begin
         step_kind = KIND_SECTOR;
         step_op   = sector_op_ff;
         step_len  = sector_size;
         step_rem  = (rem_ff >= sector_size) ? rem_ff - sector_size : 25'd0;
      end
   end

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.operation;
               addr_in  = req_data.start_address;
               len_in   = req_data.byte_length;
               off_in   = '0;
               rem_in   = req_data.byte_length;
               count_in = '0;
               unique case (req_data.operation)
                  OP_PROGRAM: begin
                     if (req_data.byte_length == 25'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = status_result(STATUS_EMPTY_PROG);
                     end else begin
                        state_in = S_COUNT;
                     end
                  end
                  OP_ERASE: begin
                     priority if (({1'b0, req_data.start_address} & sector_mask) != 25'd0)
                     begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = status_result(STATUS_UNALIGN_ADR);
                     end else if ((req_data.byte_length & sector_mask) != 25'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = status_result(STATUS_UNALIGN_LEN);
                     end else if (req_data.byte_length == 25'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = status_result(STATUS_EMPTY_ERASE);
                     end else begin
                        state_in = S_COUNT;
                     end
                  end
                  OP_CHIP: begin
                     rsp_valid_in           = 1'b1;
                     rsp_data_in            = '0;
                     rsp_data_in.status     = STATUS_OK;
                     rsp_data_in.piece_kind = KIND_CHIP;
                     rsp_data_in.opcode     = chip_op_ff;
                     rsp_data_in.last_piece = 1'b1;
                  end
                  default: ;   // unused operation code: no result
               endcase
            end
         end

         S_COUNT: begin
            priority if (rem_ff == 25'd0) begin
               // fits: rewind and emit the pieces for real
               state_in = S_EMIT;
               off_in   = '0;
               rem_in   = len_ff;
            end else if (count_ff == CNT_W'(MAX_PIECES)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = status_result(STATUS_TOO_MANY);
            end else begin
               off_in   = off_ff + step_len;
               rem_in   = step_rem;
               count_in = count_ff + CNT_W'(1);
            end
         end

         S_EMIT: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.status        = STATUS_OK;
            rsp_data_in.piece_kind    = step_kind;
            rsp_data_in.opcode        = step_op;
            rsp_data_in.piece_address = step_addr;
            rsp_data_in.piece_length  = step_len[20:0];
            rsp_data_in.data_offset   = off_ff[23:0];
            rsp_data_in.last_piece    = (step_rem == 25'd0);
            off_in = off_ff + step_len;
            rem_in = step_rem;
            if (step_rem == 25'd0) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      off_ff      <= off_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // a status-only result always closes its transaction
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.last_piece)
      else $error("status result without last_piece");

   // leaving a split request always delivers its final result
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_data.last_piece)
      else $error("sequencer went idle without a final result");

   // no empty pieces ever reach the flash
   a_piece_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.piece_kind == KIND_PROGRAM || rsp_data.piece_kind == KIND_SECTOR
                    || rsp_data.piece_kind == KIND_BLOCK) |-> rsp_data.piece_length != 21'd0)
      else $error("zero-length piece");

   // piece counter bounded by the limit
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PIECES))
      else $error("piece count beyond limit");

   // results only during a transaction or in the cycle after one was taken
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid |-> $past(busy) || $past(start))
      else $error("result without a request");

endmodule

`default_nettype wire

### tb/sv/flash_request_splitter_top_tb.sv
// Self-checking testbench for flash_request_splitter_top: directed and random
// requests under several register settings, every piece checked against a
// behavioural splitter. Depends on frs_pkg and the RTL top level only.
`default_nettype none

module flash_request_splitter_top_tb
   import frs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_PIECES    = 64;
   // operation code the block ignores
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int unsigned FULL_SPAN     = 32'h100_0000;
   localparam int unsigned ADDR_MASK     = 32'hFF_FFFF;
   // counting pass plus emitting pass, with some slack
   localparam int          SETTLE_CYCLES = 2 * MAX_PIECES + 8;

   // -------------------------------------------------------------------------
   // Expected-piece ledger: its own copy of the registers, a behavioural
   // splitter and the queue of pieces still owed by the block.
   // -------------------------------------------------------------------------
   class piece_ledger;
      logic [3:0]  page_log2   = 4'd8;
      logic [4:0]  sector_log2 = 5'd12;
      logic [4:0]  block_log2  = 5'd16;
      logic [7:0]  program_op  = 8'h02;
      logic [7:0]  sector_op   = 8'h20;
      logic [7:0]  block_op    = 8'hD8;
      logic [7:0]  chip_op     = 8'hC7;
      rsp_type     due[$];
      int unsigned mismatches  = 0;

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_PAGE_LOG2:   page_log2   = value[3:0];
            REG_SECTOR_LOG2: sector_log2 = value[4:0];
            REG_BLOCK_LOG2:  block_log2  = value[4:0];
            REG_PROGRAM_OP:  program_op  = value[7:0];
            REG_SECTOR_OP:   sector_op   = value[7:0];
            REG_BLOCK_OP:    block_op    = value[7:0];
            REG_CHIP_OP:     chip_op     = value[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned page_bytes();
         return 1 << clamp(page_log2, 4, 12);
      endfunction

      function int unsigned sector_bytes();
         return 1 << clamp(sector_log2, 9, 16);
      endfunction

      // block never smaller than a sector
      function int unsigned block_bytes();
         int unsigned sl, bl;
         sl = clamp(sector_log2, 9, 16);
         bl = clamp(block_log2, 12, 20);
         if (bl < sl) bl = sl;
         return 1 << bl;
      endfunction

      function rsp_type lone_status(logic [2:0] code);
         rsp_type r;
         r = '0;
         r.status     = code;
         r.piece_kind = KIND_NONE;
         r.last_piece = 1'b1;
         return r;
      endfunction

      function rsp_type make_piece(logic [2:0] kind, logic [7:0] op, int unsigned adr,
                                   int unsigned len, int unsigned off);
         rsp_type r;
         r = '0;
         r.status        = STATUS_OK;
         r.piece_kind    = kind;
         r.opcode        = op;
         r.piece_address = adr[23:0];
         r.piece_length  = len[20:0];
         r.data_offset   = off[23:0];
         return r;
      endfunction

      // Split one accepted request into the pieces it should produce.
      function void note_request(req_type rq);
         rsp_type     batch[$];
         int unsigned pg, sc, bk, base, rem, off, adr, room, piece;
         bit          overflow;
         pg       = page_bytes();
         sc       = sector_bytes();
         bk       = block_bytes();
         base     = rq.start_address;
         rem      = rq.byte_length;
         off      = 0;
         overflow = 1'b0;
         case (rq.operation)
            OP_CHIP: begin
               batch.push_back(make_piece(KIND_CHIP, chip_op, 0, 0, 0));
            end
            OP_PROGRAM: begin
               if (rem == 0) begin
                  batch.push_back(lone_status(STATUS_EMPTY_PROG));
               end else begin
                  while (rem != 0) begin
                     if (batch.size() >= MAX_PIECES) begin
                        overflow = 1'b1;
                        break;
                     end
                     adr   = (base + off) & ADDR_MASK;
                     room  = pg - (adr & (pg - 1));
                     piece = (room < rem) ? room : rem;
                     batch.push_back(make_piece(KIND_PROGRAM, program_op, adr, piece, off));
                     off += piece;
                     rem -= piece;
                  end
               end
            end
            OP_ERASE: begin
               // address checked before size, size before emptiness
               if ((base & (sc - 1)) != 0)
                  batch.push_back(lone_status(STATUS_UNALIGN_ADR));
               else if ((rem & (sc - 1)) != 0)
                  batch.push_back(lone_status(STATUS_UNALIGN_LEN));
               else if (rem == 0)
                  batch.push_back(lone_status(STATUS_EMPTY_ERASE));
               else begin
                  while (rem != 0) begin
                     if (batch.size() >= MAX_PIECES) begin
                        overflow = 1'b1;
                        break;
                     end
                     adr = (base + off) & ADDR_MASK;
                     if ((adr & (bk - 1)) != 0 || rem < bk) begin
                        batch.push_back(make_piece(KIND_SECTOR, sector_op, adr, sc, off));
                        off += sc;
                        rem = (rem >= sc) ? rem - sc : 0;
                     end else begin
                        batch.push_back(make_piece(KIND_BLOCK, block_op, adr, bk, off));
                        off += bk;
                        rem -= bk;
                     end
                  end
               end
            end
            default: ; // unused code: no result at all
         endcase
         if (overflow) begin
            batch.delete();
            batch.push_back(lone_status(STATUS_TOO_MANY));
         end
         if (batch.size() != 0) batch[batch.size() - 1].last_piece = 1'b1;
         foreach (batch[k]) due.push_back(batch[k]);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_piece(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, got);
            mismatches++;
            return;
         end
         want = due.pop_front();
         check_field("status",        want.status,        got.status);
         check_field("piece_kind",    want.piece_kind,    got.piece_kind);
         check_field("opcode",        want.opcode,        got.opcode);
         check_field("piece_address", want.piece_address, got.piece_address);
         check_field("piece_length",  want.piece_length,  got.piece_length);
         check_field("data_offset",   want.data_offset,   got.data_offset);
         check_field("last_piece",    want.last_piece,    got.last_piece);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   req_type     req_data = '0;
   logic        psel     = 1'b0;
   logic        penable  = 1'b0;
   logic        pwrite   = 1'b0;
   logic [4:0]  paddr    = '0;
   logic [31:0] pwdata   = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   piece_ledger ledger = new;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   flash_request_splitter_top #(
      .MAX_PIECES (MAX_PIECES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // -------------------------------------------------------------------------
   // Monitor: all inputs change by NBA at the edge, so values read here are
   // the ones the DUT sampled at this same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1) ledger.check_piece(rsp_data);
         if (start === 1'b1 && busy === 1'b0) ledger.note_request(req_data);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Present a request transaction and return at the edge that takes it.
   // start is left high so a following transaction can go straight out.
   task automatic issue(input req_type rq);
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int unsigned sender_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 96) return $urandom_range(4, 24);
      return $urandom_range(40, 200);
   endfunction

   // Hold off until every owed piece is back and the block is free, then let
   // the longest internal pass run out (an ignored request owes nothing).
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (ledger.due.size() != 0 || busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access; the register takes it on the access edge
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      ledger.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] page_l2, input logic [31:0] sector_l2,
                                input logic [31:0] block_l2, input logic [7:0] prog_op,
                                input logic [7:0] sect_op, input logic [7:0] blk_op,
                                input logic [7:0] chip_code);
      wait_idle();
      write_register(REG_PAGE_LOG2,   page_l2);
      write_register(REG_SECTOR_LOG2, sector_l2);
      write_register(REG_BLOCK_LOG2,  block_l2);
      write_register(REG_PROGRAM_OP,  {24'd0, prog_op});
      write_register(REG_SECTOR_OP,   {24'd0, sect_op});
      write_register(REG_BLOCK_OP,    {24'd0, blk_op});
      write_register(REG_CHIP_OP,     {24'd0, chip_code});
   endtask

   function automatic req_type mk(input logic [1:0] op, input logic [23:0] adr,
                                  input logic [24:0] len);
      req_type rq;
      rq.operation     = op;
      rq.start_address = adr;
      rq.byte_length   = len;
      return rq;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Random request shaped by the current geometry: most are well-formed
   // programs and aligned erases, the rest errors, chip erases and noise.
   function automatic req_type random_request();
      int unsigned pg, sc, bk, pick, adr, len;
      pg   = ledger.page_bytes();
      sc   = ledger.sector_bytes();
      bk   = ledger.block_bytes();
      adr  = $urandom_range(0, ADDR_MASK);
      len  = 0;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         return mk(OP_CHIP, adr[23:0], 25'($urandom_range(0, FULL_SPAN)));
      end else if (pick < 9) begin
         return mk(OP_UNUSED, adr[23:0], 25'($urandom_range(0, FULL_SPAN)));
      end else if (pick < 52) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            len = $urandom_range(1, 8 * pg);
         else if (pick < 80)
            len = $urandom_range(60 * pg, 68 * pg);   // around the piece limit
         else if (pick < 90) begin
            adr = (adr | (pg - 1)) - $urandom_range(0, 3);  // just short of a page end
            len = $urandom_range(1, 2 * pg);
         end else if (pick < 94)
            len = 0;
         else
            len = $urandom_range(0, FULL_SPAN);
         if ($urandom_range(0, 9) == 0)
            adr = ADDR_MASK - $urandom_range(0, 4 * pg);  // runs over the top
         return mk(OP_PROGRAM, adr[23:0], len[24:0]);
      end
      adr  = adr & ~(sc - 1);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         adr = adr & ~(bk - 1);
         len = $urandom_range(1, 4) * bk + $urandom_range(0, 8) * sc;
      end else if (pick < 55)
         len = $urandom_range(1, 70) * sc;
      else if (pick < 67) begin
         adr = FULL_SPAN - $urandom_range(1, 8) * sc;    // wraps to address zero
         len = $urandom_range(1, 40) * sc;
      end else if (pick < 77) begin
         adr = adr | $urandom_range(1, sc - 1);
         len = $urandom_range(0, 16 * sc);
      end else if (pick < 87)
         len = $urandom_range(0, 16) * sc + $urandom_range(1, sc - 1);
      else if (pick < 92)
         len = 0;
      else
         len = $urandom_range(0, FULL_SPAN) & ~(sc - 1);
      return mk(OP_ERASE, adr[23:0], len[24:0]);
   endfunction

   // Every 40 transactions open with a stretch of ten back to back
   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         issue(random_request());
         if ((i % 40) >= 10) idle_sender(sender_gap());
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      req_type plan[$];

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed set, reset geometry: 256 B pages, 4 KiB sectors, 64 KiB blocks
      plan.push_back(mk(OP_PROGRAM, 24'h000000, 25'd1));
      plan.push_back(mk(OP_PROGRAM, 24'hFFFFFF, 25'd2));          // wraps to zero
      plan.push_back(mk(OP_PROGRAM, 24'h0000FF, 25'h101));
      plan.push_back(mk(OP_PROGRAM, 24'h123456, 25'd0));          // empty program
      plan.push_back(mk(OP_PROGRAM, 24'h000000, 25'h4000));       // exactly the limit
      plan.push_back(mk(OP_PROGRAM, 24'h000000, 25'h4001));       // one piece too many
      plan.push_back(mk(OP_PROGRAM, 24'hFFFFFF, 25'h1000000));    // full address span
      plan.push_back(mk(OP_PROGRAM, 24'h000F00, 25'h3FFF));
      plan.push_back(mk(OP_ERASE,   24'h000001, 25'h1001));       // address wins over size
      plan.push_back(mk(OP_ERASE,   24'hFFFFFF, 25'd0));          // address wins over empty
      plan.push_back(mk(OP_ERASE,   24'h001000, 25'h800));        // unaligned size
      plan.push_back(mk(OP_ERASE,   24'h001000, 25'd0));          // empty erase
      plan.push_back(mk(OP_ERASE,   24'h000000, 25'h10000));      // one block
      plan.push_back(mk(OP_ERASE,   24'hFFE000, 25'h12000));      // sectors, then block at zero
      plan.push_back(mk(OP_ERASE,   24'h00F000, 25'h22000));      // sector, blocks, sector
      plan.push_back(mk(OP_ERASE,   24'h000000, 25'h1000000));    // too many blocks
      plan.push_back(mk(OP_ERASE,   24'h001000, 25'h41000));
      plan.push_back(mk(OP_ERASE,   24'hFF0000, 25'h10000));      // top block
      plan.push_back(mk(OP_ERASE,   24'h000000, 25'h40000));
      plan.push_back(mk(OP_CHIP,    24'hFFFFFF, 25'h1000000));    // address and length ignored
      plan.push_back(mk(OP_CHIP,    24'h000000, 25'd0));
      plan.push_back(mk(OP_UNUSED,  24'hABCDEF, 25'd5));          // no result expected
      foreach (plan[k]) begin
         issue(plan[k]);
         idle_sender($urandom_range(0, 2));
      end

      run_random(30);

      // Geometry extremes, saturated register values and opcode extremes.
      // Each change waits for the block to drain first.
      apply_setting(4, 9, 12, 8'h00, 8'h00, 8'h00, 8'h00);          // all minima
      run_random(45);
      apply_setting(12, 16, 20, 8'hFF, 8'hFF, 8'hFF, 8'hFF);        // all maxima
      run_random(45);
      apply_setting(0, 0, 0, rand_byte(), rand_byte(),
                    rand_byte(), rand_byte());                       // saturate low
      run_random(45);
      apply_setting(15, 31, 31, rand_byte(), rand_byte(),
                    rand_byte(), rand_byte());                       // saturate high
      run_random(45);
      apply_setting(7, 16, 12, rand_byte(), rand_byte(),
                    rand_byte(), rand_byte());                       // block raised to sector
      run_random(45);
      apply_setting($urandom_range(4, 12), $urandom_range(9, 16), $urandom_range(12, 20),
                    rand_byte(), rand_byte(), rand_byte(), rand_byte());
      run_random(45);
      apply_setting($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
                    rand_byte(), rand_byte(), rand_byte(), rand_byte());
      run_random(45);
      apply_setting(8, 12, 16, 8'h02, 8'h20, 8'hD8, 8'hC7);        // back to reset values
      run_random(45);

      // drain, then give any late stray result a chance to show
      wait_idle();
      if (ledger.mismatches == 0 && ledger.due.size() == 0)
         $display("flash_request_splitter_top_tb OK");
      else
         $display("flash_request_splitter_top_tb NOT OK");
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin
      #4_000_000;
      $display("flash_request_splitter_top_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
src/frs_pkg.sv
src/flash_request_splitter_top.sv
tb/sv/flash_request_splitter_top_tb.sv
